// ===== hdl/chrp_pkg.sv =====
// Shared types and codes for the consistent-hash ring picker.
// Holds the input and result word structs, command, status and register codes.
// No dependencies.
package chrp_pkg;

	// Field widths fixed by the word formats.
	localparam int HOST_W   = 5;
	localparam int POINT_W  = 32;
	localparam int INDEX_W  = 11;
	localparam int NB_W     = 7;
	localparam int CFG_W    = 7;
	localparam int HOST_IDS = 32;

	// Commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PICK  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_CHOSEN    = 2'd0;
	localparam logic [1:0] ST_FALLBACK  = 2'd1;
	localparam logic [1:0] ST_NONE      = 2'd2;
	localparam logic [1:0] ST_WRITE_ACK = 2'd3;

	// Health modes. The undefined mode behaves like the chosen-healthy mode.
	localparam logic [1:0] HM_HEALTHY = 2'd0;
	localparam logic [1:0] HM_IGNORE  = 2'd1;
	localparam logic [1:0] HM_ALL_OK  = 2'd2;
	localparam logic [1:0] HM_UNDEF   = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_BACKEND = 1'b0;
	localparam logic CFG_REPLICA = 1'b1;

	typedef struct packed {
		logic               command;
		logic [INDEX_W-1:0] entry_index;
		logic [POINT_W-1:0] entry_point;
		logic [HOST_W-1:0]  entry_host;
		logic [POINT_W-1:0] key;
		logic [HOST_W-1:0]  alt_rank;
		logic [1:0]         health_mode;
		logic [31:0]        health_mask;
	} in_word_t;

	typedef struct packed {
		logic [HOST_W-1:0] host;
		logic [1:0]        status;
	} out_word_t;

endpackage

// ===== hdl/consistent_hash_ring_picker.sv =====
// Consistent-hash ring picker top level: ring memory, binary search and ring walk.
// Depends on chrp_pkg and chrp_ram.
//
// Channel   Direction  Handshake            Word
// in        input      in_valid/in_ready    in_word_t (write entry or pick)
// out       output     out_valid/out_ready  out_word_t (host, status)
// cfg       input      cfg_we               cfg_index, cfg_wdata
//
// A pick runs a binary search over the ring (at most 32 probes, about log2 of
// the ring size for a sorted ring), then walks the ring entries, at most two
// laps, all bound by the one read port of the ring memory. One word is worked
// on at a time; a finished result waits in the output register while the next
// word is taken. Reset clears the control state; the ring contents are
// undefined until written.
module consistent_hash_ring_picker
	import chrp_pkg::*;
#(
	parameter int MAX_HOSTS  = 32,
	parameter int RING_DEPTH = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int NW = AW + 1;
	localparam int RW = POINT_W + HOST_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LRD   = 3'd1;
	localparam logic [2:0] S_LCMP0 = 3'd2;
	localparam logic [2:0] S_LCMP1 = 3'd3;
	localparam logic [2:0] S_WRD   = 3'd4;
	localparam logic [2:0] S_WEV   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [5:0]         backend_q;
	logic [CFG_W-1:0]   replica_q;
	logic [NB_W-1:0]    nb_q;
	logic [NW-1:0]      n_q;
	logic [POINT_W-1:0] key_q;
	logic [31:0]        mask_q;
	logic [HOST_W-1:0]  alt_q;
	logic               nh1_q;
	logic               nh2_q;
	logic               nh_cur_q;
	logic               second_q;
	logic [HOST_W-1:0]  skip_q;
	logic [NW-1:0]      low_q;
	logic [NW-1:0]      high_q;
	logic [NW-1:0]      probe_q;
	logic [5:0]         tries_q;
	logic [AW-1:0]      pos_q;
	logic [NW-1:0]      steps_q;
	logic [31:0]        visited_q;
	logic [NB_W-1:0]    pick_q;
	logic               prev_v_q;
	logic [HOST_W-1:0]  prev_q;
	logic               last_v_q;
	logic [HOST_W-1:0]  last_q;
	out_word_t          res_q;
	out_word_t          out_q;
	logic               out_valid_q;

	// Ring memory: point and host of each entry.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [RW-1:0]      ram_rdata;
	logic [AW+INDEX_W-1:0] widx_ext;

	chrp_ram #(.WIDTH(RW), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({in_data.entry_point, in_data.entry_host}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [POINT_W-1:0] rd_point;
	logic [HOST_W-1:0]  rd_host;
	assign rd_point = ram_rdata[RW-1:HOST_W];
	assign rd_host  = ram_rdata[HOST_W-1:0];

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic accept;
	assign accept = in_valid && in_ready;

	// Ring entry write on an accepted write word; indexes beyond the depth store nothing.
	assign widx_ext  = (AW + INDEX_W)'(in_data.entry_index);
	assign ram_waddr = widx_ext[AW-1:0];
	assign ram_we    = accept && (in_data.command == CMD_WRITE) &&
		(32'(in_data.entry_index) < RING_DEPTH);

	// Hosts in use and ring size from the configuration.
	logic [NB_W-1:0] nb_w;
	logic [13:0]     prod_w;
	logic [NW-1:0]   n_w;
	assign nb_w   = ({1'b0, backend_q} > NB_W'(MAX_HOSTS)) ? NB_W'(MAX_HOSTS) : {1'b0, backend_q};
	assign prod_w = 14'(nb_w) * 14'(replica_q);
	assign n_w    = (32'(prod_w) > RING_DEPTH) ? NW'(RING_DEPTH) : NW'(prod_w);

	// Clamped alternate rank.
	logic [HOST_W-1:0] alt_w;
	logic [NB_W-1:0]   nb_m1_w;
	assign nb_m1_w = nb_w - NB_W'(1);
	assign alt_w   = ({2'b0, in_data.alt_rank} > nb_m1_w) ? HOST_W'(nb_m1_w) : in_data.alt_rank;

	// Binary search probe and end conditions.
	logic [NW:0]   probe_sum;
	logic [NW-1:0] probe_w;
	logic [AW-1:0] n_m1;
	logic [NW-1:0] n_m1_ext;
	logic          loc_done;
	logic [AW-1:0] loc_pos;
	assign probe_sum = {1'b0, low_q} + {1'b0, high_q};
	assign probe_w   = probe_sum[NW:1];
	assign n_m1_ext  = n_q - NW'(1);
	assign n_m1      = n_m1_ext[AW-1:0];

	always_comb begin
		loc_done = 1'b0;
		loc_pos  = n_m1;
		case (state_q)
			S_LRD: begin
				if (tries_q == 6'd32 || probe_w >= n_q) begin
					loc_done = 1'b1;
				end
			end
			S_LCMP0: begin
				if (rd_point == key_q) begin
					loc_done = 1'b1;
					loc_pos  = probe_q[AW-1:0];
				end else if (probe_q == n_m1_ext) begin
					loc_done = 1'b1;
				end else if (rd_point > key_q && probe_q == '0) begin
					loc_done = 1'b1;
					loc_pos  = '0;
				end
			end
			S_LCMP1: begin
				if (rd_point >= key_q) begin
					loc_done = 1'b1;
					loc_pos  = AW'(probe_q + NW'(1));
				end
			end
			default: begin
				loc_done = 1'b0;
			end
		endcase
	end

	// Read address for each phase.
	always_comb begin
		case (state_q)
			S_LRD:   ram_raddr = probe_w[AW-1:0];
			S_LCMP0: ram_raddr = AW'(probe_q + NW'(1));
			default: ram_raddr = pos_q;
		endcase
	end

	// Walk step decision on the host just read.
	logic fresh;
	logic healthy;
	logic take;
	logic chosen;
	logic [NW-1:0] pos_nxt;
	assign fresh   = !visited_q[rd_host];
	assign healthy = mask_q[rd_host];
	assign take    = fresh && (healthy || !nh_cur_q);
	assign chosen  = take && (skip_q == '0);
	assign pos_nxt = {1'b0, pos_q} + NW'(1);

	out_word_t fail_res;
	assign fail_res.host   = prev_v_q ? prev_q : '0;
	assign fail_res.status = prev_v_q ? ST_FALLBACK : ST_NONE;

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			backend_q   <= '0;
			replica_q   <= CFG_W'(1);
			nb_q        <= '0;
			n_q         <= '0;
			visited_q   <= '0;
			pick_q      <= '0;
			prev_v_q    <= 1'b0;
			last_v_q    <= 1'b0;
			pos_q       <= '0;
			steps_q     <= '0;
			tries_q     <= '0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BACKEND: backend_q <= cfg_wdata[5:0];
					CFG_REPLICA: replica_q <= cfg_wdata;
					default:     replica_q <= replica_q;
				endcase
			end

			// The output register empties unless a new result moves in this cycle.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.command == CMD_WRITE) begin
							res_q.host   <= '0;
							res_q.status <= ST_WRITE_ACK;
							state_q      <= S_DONE;
						end else begin
							visited_q <= '0;
							pick_q    <= '0;
							prev_v_q  <= 1'b0;
							last_v_q  <= 1'b0;
							pos_q     <= '0;
							nb_q      <= nb_w;
							n_q       <= n_w;
							key_q     <= in_data.key;
							mask_q    <= in_data.health_mask;
							alt_q     <= alt_w;
							nh1_q     <= (in_data.health_mode == HM_ALL_OK);
							nh2_q     <= (in_data.health_mode != HM_IGNORE);
							low_q     <= '0;
							high_q    <= n_w;
							tries_q   <= '0;
							if (nb_w == '0 || n_w == '0) begin
								res_q.host   <= '0;
								res_q.status <= ST_NONE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_LRD;
							end
						end
					end
				end
				S_LRD, S_LCMP0, S_LCMP1: begin
					if (loc_done) begin
						pos_q   <= loc_pos;
						steps_q <= '0;
						if (alt_q != '0) begin
							skip_q   <= alt_q - HOST_W'(1);
							nh_cur_q <= nh1_q;
							second_q <= 1'b0;
						end else begin
							skip_q   <= '0;
							nh_cur_q <= nh2_q;
							second_q <= 1'b1;
						end
						state_q <= S_WRD;
					end else if (state_q == S_LRD) begin
						probe_q <= probe_w;
						state_q <= S_LCMP0;
					end else if (state_q == S_LCMP0) begin
						if (rd_point < key_q) begin
							state_q <= S_LCMP1;
						end else begin
							high_q  <= probe_q;
							tries_q <= tries_q + 6'd1;
							state_q <= S_LRD;
						end
					end else begin
						low_q   <= probe_q;
						tries_q <= tries_q + 6'd1;
						state_q <= S_LRD;
					end
				end
				S_WRD: begin
					if (steps_q >= n_q || pick_q >= nb_q) begin
						res_q   <= fail_res;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WEV;
					end
				end
				S_WEV: begin
					if (fresh) begin
						visited_q <= visited_q | (32'd1 << rd_host);
						pick_q    <= pick_q + NB_W'(1);
					end
					if (take && skip_q != '0) begin
						skip_q <= skip_q - HOST_W'(1);
					end
					if (fresh && healthy && skip_q != '0) begin
						prev_q   <= rd_host;
						prev_v_q <= 1'b1;
					end
					if (chosen) begin
						if (last_v_q) begin
							prev_q   <= last_q;
							prev_v_q <= 1'b1;
						end
						last_q   <= rd_host;
						last_v_q <= 1'b1;
						if (second_q) begin
							res_q.host   <= rd_host;
							res_q.status <= ST_CHOSEN;
							state_q      <= S_DONE;
						end else begin
							second_q <= 1'b1;
							skip_q   <= '0;
							nh_cur_q <= nh2_q;
							steps_q  <= '0;
							state_q  <= S_WRD;
						end
					end else begin
						pos_q   <= (pos_nxt >= n_q) ? '0 : pos_nxt[AW-1:0];
						steps_q <= steps_q + NW'(1);
						state_q <= S_WRD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The visited mask and the pick counter advance together.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(visited_q) == 32'(pick_q))
		else $error("visited mask and pick count disagree");

	// The walk position always lies inside the ring in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRD || state_q == S_WEV) |-> ({1'b0, pos_q} < n_q))
		else $error("walk position outside ring");

	// Results without a host carry host zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == ST_NONE || out_q.status == ST_WRITE_ACK))
		|-> (out_q.host == '0))
		else $error("host not zero on none or write ack");

	// The search never runs beyond its probe bound.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LCMP0 || state_q == S_LCMP1) |-> (tries_q < 6'd32))
		else $error("search probe bound exceeded");

endmodule

// ===== hdl/chrp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== dv/tb_consistent_hash_ring_picker.sv =====
// Self-checking testbench for the consistent-hash ring picker: loads rings,
// issues picks under several host and replica settings and checks each result.
// Depends on chrp_pkg and the consistent_hash_ring_picker RTL.
module tb_consistent_hash_ring_picker;
	import chrp_pkg::*;

	localparam int DEPTH   = 2048;
	localparam int NHOSTS  = 32;
	localparam int NO_HOST = 63;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_word_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_word_t         out_data;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_BACKEND;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	consistent_hash_ring_picker DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the ring, the registers and the walk state.
	logic [31:0] shadow_point [DEPTH];
	logic [4:0]  shadow_host [DEPTH];
	int unsigned shadow_backends = 0;
	int unsigned shadow_replicas = 1;
	int unsigned seen_mask, walk_at, prev_healthy, last_picked, hosts_counted;

	out_word_t pending_results[$];
	int        errors = 0;
	int        items_sent = 0;
	int        picks_sent = 0;
	int        phases_run = 0;
	bit        quiet = 1'b0;

	// First ring position at or above the key, bounded to 32 probes.
	function automatic int unsigned find_slot(int unsigned n, logic [31:0] k);
		int unsigned lo, hi, p;
		lo = 0;
		hi = n;
		for (int t = 0; t < 32; t++) begin
			p = (hi + lo) / 2;
			if (p >= n) return n - 1;
			if (shadow_point[p] == k) return p;
			if (p == n - 1) return n - 1;
			if (shadow_point[p] < k && shadow_point[p+1] >= k) return p + 1;
			if (shadow_point[p] > k) begin
				if (p == 0) return 0;
				hi = p;
			end else begin
				lo = p;
			end
		end
		return n - 1;
	endfunction

	// One walk around the ring; returns the chosen host or -1.
	function automatic int walk_ring(int unsigned n, int unsigned nb, int unsigned skip,
			bit need_ok, logic [31:0] mask);
		int unsigned c;
		int chosen, target;
		if (hosts_counted >= nb) return -1;
		for (int unsigned s = 0; s < n && hosts_counted < nb; s++) begin
			c = shadow_host[walk_at];
			if (!seen_mask[c]) begin
				chosen = -1;
				target = 0;
				seen_mask[c] = 1'b1;
				hosts_counted++;
				if (mask[c]) begin
					if (skip == 0) begin
						chosen = c;
						target = 2;
					end else begin
						skip--;
						target = 1;
					end
				end else if (!need_ok) begin
					if (skip == 0) begin
						chosen = c;
						target = 2;
					end else begin
						skip--;
					end
				end
				if (target == 2 && last_picked != NO_HOST) prev_healthy = last_picked;
				if (target == 1) prev_healthy = c;
				if (target == 2) last_picked = c;
				if (chosen >= 0) return chosen;
			end
			walk_at++;
			if (walk_at >= n) walk_at = 0;
		end
		return -1;
	endfunction

	// Expected result of one word, updating the shadow state.
	function automatic out_word_t predict_pick(in_word_t w);
		out_word_t r;
		int unsigned nb, n, alt;
		logic [1:0] mode;
		bit failed;
		r = '0;
		if (w.command == CMD_WRITE) begin
			shadow_point[w.entry_index] = w.entry_point;
			shadow_host[w.entry_index] = w.entry_host;
			r.status = ST_WRITE_ACK;
			return r;
		end
		seen_mask = 0;
		hosts_counted = 0;
		prev_healthy = NO_HOST;
		last_picked = NO_HOST;
		walk_at = 0;
		nb = shadow_backends > NHOSTS ? NHOSTS : shadow_backends;
		n = nb * shadow_replicas;
		if (n > DEPTH) n = DEPTH;
		if (nb == 0 || n == 0) begin
			r.status = ST_NONE;
			return r;
		end
		alt = w.alt_rank;
		if (alt > nb - 1) alt = nb - 1;
		mode = w.health_mode == HM_UNDEF ? HM_HEALTHY : w.health_mode;
		walk_at = find_slot(n, w.key);
		failed = 1'b0;
		if (alt > 0 && walk_ring(n, nb, alt - 1, mode == HM_ALL_OK, w.health_mask) < 0)
			failed = 1'b1;
		else if (walk_ring(n, nb, 0, mode != HM_IGNORE, w.health_mask) < 0)
			failed = 1'b1;
		if (failed) begin
			if (prev_healthy != NO_HOST) begin
				r.host = prev_healthy[4:0];
				r.status = ST_FALLBACK;
			end else begin
				r.status = ST_NONE;
			end
		end else begin
			r.host = last_picked[4:0];
			r.status = ST_CHOSEN;
		end
		return r;
	endfunction

	// Drive one word; called and returning at a falling edge.
	task automatic send_word(in_word_t w, bit typed, out_word_t typed_result);
		int gap;
		out_word_t r;
		gap = (!quiet && $urandom_range(99) < 15) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		r = predict_pick(w);
		pending_results.push_back(typed ? typed_result : r);
		items_sent++;
		if (w.command == CMD_PICK) picks_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BACKEND) shadow_backends = val & 63;
		else shadow_replicas = val & 127;
	endtask

	function automatic in_word_t ring_word(int unsigned idx, logic [31:0] pt, logic [4:0] h);
		in_word_t w;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		w.command = CMD_WRITE;
		w.entry_index = idx[INDEX_W-1:0];
		w.entry_point = pt;
		w.entry_host = h;
		return w;
	endfunction

	function automatic in_word_t pick_word(int unsigned n);
		in_word_t w;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		w.command = CMD_PICK;
		case ($urandom_range(7))
			0: w.key = 32'd0;
			1: w.key = '1;
			2: if (n != 0) w.key = shadow_point[$urandom_range(n - 1)];
			default: ;
		endcase
		case ($urandom_range(3))
			0: w.health_mask = '1;
			1: w.health_mask = '0;
			default: ;
		endcase
		if ($urandom_range(1)) w.alt_rank = 5'($urandom_range(3));
		return w;
	endfunction

	// Directed words run with the reset settings, so the results are fixed.
	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t res;
	} stim_row_t;

	stim_row_t directed [6] = '{
		'{'{CMD_WRITE, 11'd2047, '1, 5'd31, '0, '0, HM_HEALTHY, '0}, 1'b1,
			'{5'd0, ST_WRITE_ACK}},
		'{'{CMD_WRITE, 11'd0, '0, 5'd0, '1, '1, HM_UNDEF, '1}, 1'b1, '{5'd0, ST_WRITE_ACK}},
		'{'{CMD_PICK, '0, '0, '0, '0, '0, HM_HEALTHY, '0}, 1'b1, '{5'd0, ST_NONE}},
		'{'{CMD_PICK, '1, '1, '1, '1, '1, HM_UNDEF, '1}, 1'b1, '{5'd0, ST_NONE}},
		'{'{CMD_PICK, '0, '0, '0, 32'h8000_0000, 5'd16, HM_IGNORE, '1}, 1'b0, '0},
		'{'{CMD_PICK, '0, '0, '0, 32'h1234_5678, 5'd1, HM_ALL_OK, '0}, 1'b0, '0}
	};

	// Register settings walked first: extremes, then odd cases.
	int unsigned plan_nb [7] = '{1, 32, 63, 7, 0, 32, 5};
	int unsigned plan_rep[7] = '{64, 1, 2, 0, 5, 2, 3};

	initial begin
		int unsigned nb, rep, n, pt, phase;
		bit sorted;
		in_word_t w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].res);
		phase = 0;
		while (items_sent < 750) begin
			if (phase < 7) begin
				nb = plan_nb[phase];
				rep = plan_rep[phase];
			end else begin
				nb = $urandom_range(1, 32);
				rep = $urandom_range(1, 4);
			end
			quiet = (phase >= 9 && phase <= 11);
			write_reg(CFG_BACKEND, nb);
			write_reg(CFG_REPLICA, rep);
			n = (nb > NHOSTS ? NHOSTS : nb) * rep;
			if (n > DEPTH) n = DEPTH;
			// Mostly sorted rings; a few are left unsorted on purpose.
			sorted = $urandom_range(9) != 0;
			pt = $urandom_range(1000);
			for (int unsigned i = 0; i < n; i++) begin
				pt += $urandom_range(1 << 24);
				send_word(ring_word(i, sorted ? pt : $urandom,
					5'($urandom_range(3) == 0 ? $urandom_range(31) :
					(i % (nb == 0 ? 1 : nb)))),
					1'b0, '0);
			end
			for (int k = 0; k < 30; k++) begin
				if ($urandom_range(9) == 0)
					w = ring_word($urandom_range(2047), $urandom, 5'($urandom_range(31)));
				else
					w = pick_word(n);
				send_word(w, 1'b0, '0);
			end
			phase++;
			phases_run++;
		end
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		$display("Ran %0d words (%0d picks) over %0d register settings.",
			items_sent, picks_sent, phases_run);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Receiver stalls, with a quiet stretch in the middle of the run.
	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 15);
	end

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: host %0d status %0d",
					out_data.host, out_data.status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_data.host !== e.host) begin
					$error("host expected %0d actual %0d", e.host, out_data.host);
					errors++;
				end
				if (out_data.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, out_data.status);
					errors++;
				end
			end
		end
	end

	initial begin
		#(12 * 3000000);
		$display("Verification failed");
		$finish;
	end

endmodule
